FILE: sv/rar_pkg.sv
// Shared constants, action codes and the front-to-back item type for the rational unit.
`default_nettype none

package rar_pkg;

	// result word width and derived counter width
	localparam int RES_W = 32;
	localparam int CNT_W = $clog2(RES_W);

	// defaults for top-level parameters
	localparam int IN_WIDTH_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// action codes
	localparam int ACT_W = 2;
	localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SUB = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MUL = 2'd2;
	localparam logic [ACT_W-1:0] ACT_DIV = 2'd3;

	// classified item handed from front to back
	typedef struct packed {
		logic [RES_W-1:0] raw_num;
		logic [RES_W-1:0] raw_den;
		logic [RES_W-1:0] mag_num;
		logic [RES_W-1:0] mag_den;
		logic             neg;
		logic             do_red;
	} rar_item_t;

endpackage

`default_nettype wire

FILE: sv/rar_fifo.sv
// Short queue of classified items between the front and the back.
`default_nettype none

module rar_fifo #(
	parameter int DEPTH = 2
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  rar_pkg::rar_item_t din,
	output logic              full,
	input  wire               pop,
	output rar_pkg::rar_item_t dout,
	output logic              empty
);
	import rar_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rar_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/rar_front.sv
// Front end: takes a beat, forms the cross products on one multiplier and classifies the result.
`default_nettype none

module rar_front #(
	parameter int IN_WIDTH = rar_pkg::IN_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  [rar_pkg::ACT_W-1:0]       action,
	input  wire  signed [IN_WIDTH-1:0]      num_a,
	input  wire  signed [IN_WIDTH-1:0]      den_a,
	input  wire  signed [IN_WIDTH-1:0]      num_b,
	input  wire  signed [IN_WIDTH-1:0]      den_b,
	output logic                            q_push,
	output rar_pkg::rar_item_t              q_item,
	input  wire                             q_full
);
	import rar_pkg::*;

	localparam int PW = (2*IN_WIDTH > RES_W) ? 2*IN_WIDTH : RES_W;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL0 = 3'd1;
	localparam logic [2:0] F_MUL1 = 3'd2;
	localparam logic [2:0] F_MUL2 = 3'd3;
	localparam logic [2:0] F_COMB = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic [2:0]                 state_q;
	logic [ACT_W-1:0]           act_q;
	logic signed [IN_WIDTH-1:0] na_q, da_q, nb_q, db_q;
	logic [RES_W-1:0]           p0_q, p1_q, p2_q;
	logic [RES_W-1:0]           rn_q, rd_q;

	logic signed [IN_WIDTH-1:0]   op_x, op_y;
	logic signed [2*IN_WIDTH-1:0] prod_full;
	logic signed [PW-1:0]         prod_ext;
	logic [RES_W-1:0]             prod32;
	logic [RES_W-1:0]             rn_nx, rd_nx;
	logic                         sn, sd;

	assign full = (state_q != F_IDLE);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			F_MUL0: begin
				op_x = na_q;
				op_y = (act_q == ACT_MUL) ? nb_q : db_q;
			end
			F_MUL1: begin
				op_x = nb_q;
				op_y = da_q;
			end
			default: begin
				op_x = da_q;
				op_y = db_q;
			end
		endcase
	end

	// product wrapped to the result width
	assign prod_full = (2*IN_WIDTH)'(op_x) * (2*IN_WIDTH)'(op_y);
	assign prod_ext  = PW'(prod_full);
	assign prod32    = prod_ext[RES_W-1:0];

	// combine products per action
	always_comb begin
		case (act_q)
			ACT_ADD: rn_nx = p0_q + p1_q;
			ACT_SUB: rn_nx = p0_q - p1_q;
			default: rn_nx = p0_q;
		endcase
		rd_nx = (act_q == ACT_DIV) ? p1_q : p2_q;
	end

	// classification into sign and magnitude
	assign sn = rn_q[RES_W-1];
	assign sd = rd_q[RES_W-1];
	always_comb begin
		q_item.raw_num = rn_q;
		q_item.raw_den = rd_q;
		q_item.mag_num = sn ? (RES_W'(0) - rn_q) : rn_q;
		q_item.mag_den = sd ? (RES_W'(0) - rd_q) : rd_q;
		q_item.neg     = sn ^ sd;
		q_item.do_red  = (rn_q != '0) && (rd_q != '0);
	end
	assign q_push = (state_q == F_PUSH);

	// operand and product registers
	always_ff @(posedge clk) begin
		if (push && !full) begin
			act_q <= action;
			na_q  <= num_a;
			da_q  <= den_a;
			nb_q  <= num_b;
			db_q  <= den_b;
		end
		if (state_q == F_MUL0) p0_q <= prod32;
		if (state_q == F_MUL1) p1_q <= prod32;
		if (state_q == F_MUL2) p2_q <= prod32;
		if (state_q == F_COMB) begin
			rn_q <= rn_nx;
			rd_q <= rd_nx;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (push) state_q <= F_MUL0;
				F_MUL0: state_q <= F_MUL1;
				F_MUL1: state_q <= F_MUL2;
				F_MUL2: state_q <= F_COMB;
				F_COMB: state_q <= F_PUSH;
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/rar_back.sv
// Back end: binary gcd, two restoring divisions, sign fix-up and the result register.
`default_nettype none

module rar_back (
	input  wire                             clk,
	input  wire                             arst_n,
	output logic                            q_pop,
	input  rar_pkg::rar_item_t              q_item,
	input  wire                             q_empty,
	output logic                            empty,
	input  wire                             pop,
	output logic [rar_pkg::RES_W-1:0]       raw_num,
	output logic [rar_pkg::RES_W-1:0]       raw_den,
	output logic [rar_pkg::RES_W-1:0]       red_num,
	output logic [rar_pkg::RES_W-1:0]       red_den
);
	import rar_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_GCD  = 3'd1;
	localparam logic [2:0] B_DIVN = 3'd2;
	localparam logic [2:0] B_DIVD = 3'd3;
	localparam logic [2:0] B_DONE = 3'd4;

	logic [2:0]       state_q;
	rar_item_t        it_q;
	logic [RES_W-1:0] a_q, b_q, g_q;
	logic [CNT_W-1:0] k_q, cnt_q;
	logic [RES_W-1:0] rem_q, quo_q;
	logic [RES_W-1:0] qn_q, qd_q;
	logic             out_valid_q;

	logic [RES_W-1:0] a_sub_b, b_sub_a;
	logic             a_gt_b;
	logic [RES_W:0]   rem_sh, rem_diff;
	logic             rem_ge;
	logic [RES_W-1:0] rem_nx, quo_nx;
	logic             out_load;
	logic [RES_W-1:0] fin_num, fin_den;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign empty    = !out_valid_q;
	assign out_load = (state_q == B_DONE) && (!out_valid_q || pop);

	// gcd step datapath
	assign a_sub_b = a_q - b_q;
	assign b_sub_a = b_q - a_q;
	assign a_gt_b  = (a_q > b_q);

	// restoring divider step
	assign rem_sh   = {rem_q, quo_q[RES_W-1]};
	assign rem_diff = rem_sh - {1'b0, g_q};
	assign rem_ge   = !rem_diff[RES_W];
	assign rem_nx   = rem_ge ? rem_diff[RES_W-1:0] : rem_sh[RES_W-1:0];
	assign quo_nx   = {quo_q[RES_W-2:0], rem_ge};

	// final sign placement; zero denominator passes the numerator through
	always_comb begin
		if (qd_q == '0) begin
			fin_num = it_q.raw_num;
			fin_den = '0;
		end else begin
			fin_num = it_q.neg ? (RES_W'(0) - qn_q) : qn_q;
			fin_den = qd_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					it_q <= q_item;
					a_q  <= q_item.mag_num;
					b_q  <= q_item.mag_den;
					k_q  <= '0;
					qn_q <= q_item.mag_num;
					qd_q <= q_item.mag_den;
				end
			end
			B_GCD: begin
				if (a_q == b_q) begin
					g_q   <= a_q << k_q;
					quo_q <= it_q.mag_num;
					rem_q <= '0;
					cnt_q <= CNT_W'(RES_W-1);
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_gt_b) begin
					a_q <= a_sub_b;
				end else begin
					b_q <= b_sub_a;
				end
			end
			B_DIVN: begin
				if (cnt_q == '0) begin
					qn_q  <= quo_nx;
					quo_q <= it_q.mag_den;
					rem_q <= '0;
					cnt_q <= CNT_W'(RES_W-1);
				end else begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			B_DIVD: begin
				if (cnt_q == '0) begin
					qd_q <= quo_nx;
				end else begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			raw_num <= it_q.raw_num;
			raw_den <= it_q.raw_den;
			red_num <= fin_num;
			red_den <= fin_den;
		end
	end

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= q_item.do_red ? B_GCD : B_DONE;
					end
				end
				B_GCD:  if (a_q == b_q) state_q <= B_DIVN;
				B_DIVN: if (cnt_q == '0) state_q <= B_DIVD;
				B_DIVD: if (cnt_q == '0) state_q <= B_DONE;
				B_DONE: if (out_load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/rational_arith_reduce_unit.sv
// Top level of the rational add/sub/mul/div unit with gcd reduction.
//
//  channel   direction  handshake          beat contents
//  input     in         push / full        action, num_a, den_a, num_b, den_b
//  result    out        empty / pop        raw_num, raw_den, red_num, red_den
//
// Front: three products on one shared multiplier, then combine and classify; it takes no new
// beat until the current one is in the queue. Back, when reducing: a binary gcd loop of one
// shift or subtract per cycle, then two restoring divisions on one divider; if not, straight to the result.
// The queue lets the front take new beats while the back works; a waiting result holds
// the back in its last state until popped. Reset clears all control, no clearing pass.
`default_nettype none

module rational_arith_reduce_unit #(
	parameter int IN_WIDTH    = rar_pkg::IN_WIDTH_DEF,
	parameter int QUEUE_DEPTH = rar_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  [rar_pkg::ACT_W-1:0]       action,
	input  wire  signed [IN_WIDTH-1:0]      num_a,
	input  wire  signed [IN_WIDTH-1:0]      den_a,
	input  wire  signed [IN_WIDTH-1:0]      num_b,
	input  wire  signed [IN_WIDTH-1:0]      den_b,
	output logic                            empty,
	input  wire                             pop,
	output logic signed [rar_pkg::RES_W-1:0] raw_num,
	output logic signed [rar_pkg::RES_W-1:0] raw_den,
	output logic signed [rar_pkg::RES_W-1:0] red_num,
	output logic signed [rar_pkg::RES_W-1:0] red_den
);
	import rar_pkg::*;

	logic      q_push, q_full, q_pop, q_empty;
	rar_item_t q_din, q_dout;

	// classify
	rar_front #(
		.IN_WIDTH(IN_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.action (action),
		.num_a  (num_a),
		.den_a  (den_a),
		.num_b  (num_b),
		.den_b  (den_b),
		.q_push (q_push),
		.q_item (q_din),
		.q_full (q_full)
	);

	// decoupling queue
	rar_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// reduce
	rar_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_pop   (q_pop),
		.q_item  (q_dout),
		.q_empty (q_empty),
		.empty   (empty),
		.pop     (pop),
		.raw_num (raw_num),
		.raw_den (raw_den),
		.red_num (red_num),
		.red_den (red_den)
	);

`ifndef SYNTH
	// front holds its beat steady while the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_full |=> q_push && $stable(q_din))
		else $error("queue beat dropped or changed while full");

	// back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// zero denominator passes the numerator through
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (red_den == '0) |-> (red_num == raw_num))
		else $error("zero denominator altered numerator");

	// zero numerator over nonzero denominator stays zero
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (raw_num == '0) && (raw_den != '0) |-> (red_num == '0))
		else $error("zero numerator not kept");
`endif

endmodule

`default_nettype wire

FILE: bench/rational_arith_reduce_unit_test.sv
// Self-checking bench for the rational add/sub/mul/div unit with gcd reduction.
`timescale 1ns / 1ps

module rational_arith_reduce_unit_test;
	import rar_pkg::*;

	localparam int IW          = IN_WIDTH_DEF;
	localparam int RANDOM_OPS  = 450;
	localparam int TAIL_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1_000_000;

	// one input beat
	typedef struct {
		logic [ACT_W-1:0]     action;
		logic signed [IW-1:0] num_a;
		logic signed [IW-1:0] den_a;
		logic signed [IW-1:0] num_b;
		logic signed [IW-1:0] den_b;
	} operands_t;

	// one result beat
	typedef struct {
		logic [RES_W-1:0] raw_num;
		logic [RES_W-1:0] raw_den;
		logic [RES_W-1:0] red_num;
		logic [RES_W-1:0] red_den;
	} ratio_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [ACT_W-1:0] action = '0;
	logic signed [IW-1:0] num_a = '0;
	logic signed [IW-1:0] den_a = '0;
	logic signed [IW-1:0] num_b = '0;
	logic signed [IW-1:0] den_b = '0;
	wire full;
	wire empty;
	wire signed [RES_W-1:0] raw_num;
	wire signed [RES_W-1:0] raw_den;
	wire signed [RES_W-1:0] red_num;
	wire signed [RES_W-1:0] red_den;

	operands_t pending_ops[$];
	ratio_t    expected_ratios[$];
	ratio_t    oldest_ratio;
	int        errors = 0;
	int        cycles = 0;
	int        send_gap = 0;
	int        send_calm = 0;
	int        recv_gap = 0;
	int        recv_calm = 0;

	rational_arith_reduce_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.action  (action),
		.num_a   (num_a),
		.den_a   (den_a),
		.num_b   (num_b),
		.den_b   (den_b),
		.empty   (empty),
		.pop     (pop),
		.raw_num (raw_num),
		.raw_den (raw_den),
		.red_num (red_num),
		.red_den (red_den)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cross multiply, then reduce by the gcd of the magnitudes and normalize the sign
	function automatic ratio_t predict_ratio(operands_t op);
		longint na, da, nb, db, pn, pd;
		logic [RES_W-1:0] un, ud, mn, md, a, b, t;
		logic sn, sd;
		ratio_t r;
		na = longint'(op.num_a);
		da = longint'(op.den_a);
		nb = longint'(op.num_b);
		db = longint'(op.den_b);
		case (op.action)
			ACT_ADD: begin
				pn = na * db + nb * da;
				pd = da * db;
			end
			ACT_SUB: begin
				pn = na * db - nb * da;
				pd = da * db;
			end
			ACT_MUL: begin
				pn = na * nb;
				pd = da * db;
			end
			default: begin
				pn = na * db;
				pd = nb * da;
			end
		endcase
		un = pn[RES_W-1:0];
		ud = pd[RES_W-1:0];
		sn = un[RES_W-1];
		sd = ud[RES_W-1];
		mn = sn ? (32'd0 - un) : un;
		md = sd ? (32'd0 - ud) : ud;
		if (mn != 0 && md != 0) begin
			a = mn;
			b = md;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			mn = mn / a;
			md = md / a;
		end
		r.raw_num = un;
		r.raw_den = ud;
		if (md == 0) begin
			r.red_num = un;
			r.red_den = '0;
		end else begin
			r.red_num = (sn != sd) ? (32'd0 - mn) : mn;
			r.red_den = md;
		end
		return r;
	endfunction

	// idle length: mostly short, a few long, now and then a stretch with none
	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	// small values give frequent reductions; specials hit zero and the extremes
	function automatic logic [IW-1:0] pick_operand();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return IW'($urandom_range(0, 40) - 20);
		if (r < 4) begin
			case ($urandom_range(0, 5))
				0: return '0;
				1: return 16'h7fff;
				2: return 16'h8001;
				3: return 16'h8000;
				4: return 16'd1 << $urandom_range(0, 14);
				default: return 16'hffff;
			endcase
		end
		return IW'($urandom_range(0, 65535));
	endfunction

	function automatic int field_bad(string fname, logic [RES_W-1:0] want,
			logic [RES_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, fname, $signed(want),
				$signed(got));
			return 1;
		end
		return 0;
	endfunction

	task automatic queue_op(logic [ACT_W-1:0] act, logic [IW-1:0] na, logic [IW-1:0] da,
			logic [IW-1:0] nb, logic [IW-1:0] db);
		operands_t op;
		op.action = act;
		op.num_a = na;
		op.den_a = da;
		op.num_b = nb;
		op.den_b = db;
		pending_ops.push_back(op);
	endtask

	// driver: a beat leaves the queue when it is taken, then an idle gap may follow
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_ratios.push_back(predict_ratio(pending_ops[0]));
				void'(pending_ops.pop_front());
				send_gap = pick_idle(send_calm);
			end
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					action <= pending_ops[0].action;
					num_a <= pending_ops[0].num_a;
					den_a <= pending_ops[0].den_a;
					num_b <= pending_ops[0].num_b;
					den_b <= pending_ops[0].den_b;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each popped beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_ratios.size() == 0) begin
					$display("%0t: unexpected result %0d/%0d reduced %0d/%0d", $time,
						raw_num, raw_den, red_num, red_den);
					errors++;
				end else begin
					oldest_ratio = expected_ratios.pop_front();
					errors += field_bad("raw_num", oldest_ratio.raw_num, raw_num);
					errors += field_bad("raw_den", oldest_ratio.raw_den, raw_den);
					errors += field_bad("red_num", oldest_ratio.red_num, red_num);
					errors += field_bad("red_den", oldest_ratio.red_den, red_den);
				end
				recv_gap = pick_idle(recv_calm);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// directed beats
		queue_op(ACT_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
		queue_op(ACT_SUB, 16'd3, 16'd4, 16'd3, 16'd4);        // zero numerator
		queue_op(ACT_MUL, 16'd2, 16'd3, 16'd3, -16'sd4);      // negative denominator
		queue_op(ACT_DIV, 16'd1, 16'd2, 16'd3, 16'd4);
		queue_op(ACT_DIV, 16'd5, 16'd7, 16'd0, 16'd3);        // divide by a zero fraction
		queue_op(ACT_ADD, 16'd1, 16'd0, 16'd1, 16'd0);        // 0/0
		queue_op(ACT_MUL, 16'd0, 16'd2, 16'd3, -16'sd3);      // 0 over negative
		queue_op(ACT_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		queue_op(ACT_ADD, 16'h8001, 16'h7fff, 16'h8001, 16'h7fff);
		queue_op(ACT_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000); // wraps to 2^31
		queue_op(ACT_SUB, 16'h7fff, 16'h8001, 16'h8001, 16'h7fff);
		queue_op(ACT_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
		queue_op(ACT_MUL, 16'h8000, 16'hffff, 16'h7fff, 16'h8000);
		queue_op(ACT_DIV, 16'h7fff, 16'd1, 16'd1, 16'h7fff);
		queue_op(ACT_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		queue_op(ACT_SUB, 16'd0, 16'd0, 16'd0, 16'd0);
		queue_op(ACT_ADD, -16'sd6, -16'sd9, 16'd4, 16'd6);
		queue_op(ACT_MUL, 16'd12, -16'sd18, -16'sd15, 16'd25);
		queue_op(ACT_SUB, 16'd5, 16'd0, 16'd3, 16'd7);        // x/0 with nonzero numerator
		queue_op(ACT_DIV, 16'hffff, 16'd0, 16'h8000, 16'h7fff);

		// random beats
		repeat (RANDOM_OPS)
			queue_op(ACT_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || expected_ratios.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
